[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by lesf_dp_stage.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked during reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(expr), msg)

`endif

[hdl/lesf_pkg.sv]
// ----------------------------------------------------------------------------
// lesf_pkg
// Types, widths and helpers for the largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 4096;

   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int LEN_W  = COL_W + 1;
   localparam int CFG_W  = 11;
   localparam int CHAR_W = 8;
   localparam int SIZE_W = 11;

   localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

   localparam int RSP_FIELDS_W = SIZE_W + ROW_W + COL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [CFG_W-1:0]  ROW_LENGTH_RST = CFG_W'(1024);
   localparam logic [CHAR_W-1:0] OBSTACLE_RST   = CHAR_W'(111);

   typedef enum logic [0:0] {
      CSR_ROW_LENGTH = 1'b0,
      CSR_OBSTACLE   = 1'b1
   } csr_index_type;

   // cell on its way from the scan counters to the size stage
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              row_nz;
      logic              skip;
      logic              blocked;
      logic              last;
      logic              ovf;
      logic              fwd;
      logic [SIZE_W-1:0] fwd_size;
   } item_type;

   typedef struct packed {
      logic              en;
      logic [COL_W-1:0]  addr;
      logic [SIZE_W-1:0] data;
   } lb_wr_type;

   function automatic logic [SIZE_W-1:0] min3_size(input logic [SIZE_W-1:0] a,
                                                   input logic [SIZE_W-1:0] b,
                                                   input logic [SIZE_W-1:0] c);
      logic [SIZE_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

endpackage

[hdl/largest_empty_square_finder.sv]
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Maximal-square search over a character grid streamed in row-major order.
// ----------------------------------------------------------------------------
// One cell is taken per clock, sustained, with no gaps between rows or maps;
// that figure is set by the single line buffer read and write per cell, the
// write of one cell being forwarded to a read of the same column in the next.
// The end-of-map word is held in the item register, then sets the result register,
// and the input keeps flowing while the result waits; input stalls only while a
// second end-of-map word meets a result that is still not taken. No clearing
// pass follows reset: the first row of each map ignores the line buffer data.
// ----------------------------------------------------------------------------
module largest_empty_square_finder
   import lesf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_W-1:0]     req_tdata,   // cell_char
   input  logic                  req_tlast,   // end_of_map
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // square_size, top_row, left_col, zero pad
   output logic                  rsp_tuser,   // rows_exceeded
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic [CFG_W-1:0]  row_length_ff, row_length_in;
   logic [CHAR_W-1:0] obstacle_ff, obstacle_in;
   logic              accept;
   logic              ready;
   logic [COL_W-1:0]  rd_addr;
   logic [SIZE_W-1:0] rd_data;
   item_type          item;
   lb_wr_type         wr;
   logic [SIZE_W-1:0] square_size;
   logic [ROW_W-1:0]  top_row;
   logic [COL_W-1:0]  left_col;

   always_comb begin
      row_length_in = row_length_ff;
      obstacle_in   = obstacle_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_LENGTH: begin
               row_length_in = csr_wdata;
            end
            CSR_OBSTACLE: begin
               obstacle_in = csr_wdata[CHAR_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RST;
         obstacle_ff   <= OBSTACLE_RST;
      end else begin
         row_length_ff <= row_length_in;
         obstacle_ff   <= obstacle_in;
      end
   end

   assign req_tready = ready;
   assign accept     = req_tvalid && ready;

   lesf_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cell_char     (req_tdata),
      .last          (req_tlast),
      .row_length    (row_length_ff),
      .obstacle_char (obstacle_ff),
      .wr            (wr),
      .rd_addr       (rd_addr),
      .item          (item)
   );

   lesf_line_buffer u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   lesf_dp_stage u_dp_stage (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item_in       (item),
      .rd_data       (rd_data),
      .wr            (wr),
      .ready         (ready),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .square_size   (square_size),
      .top_row       (top_row),
      .left_col      (left_col),
      .rows_exceeded (rsp_tuser)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_FIELDS_W)'(0), left_col, top_row, square_size};

endmodule

[hdl/lesf_line_buffer.sv]
// ----------------------------------------------------------------------------
// lesf_line_buffer
// Square sizes of the previous row, one entry per column, registered read.
// ----------------------------------------------------------------------------
module lesf_line_buffer
   import lesf_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   output logic [SIZE_W-1:0] rd_data,
   input  lb_wr_type         wr
);

   logic [SIZE_W-1:0] mem_ff [MAX_COLS];
   logic [SIZE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lesf_scan.sv]
// ----------------------------------------------------------------------------
// lesf_scan
// Column, row and overflow counters; issues the line buffer read per word.
// ----------------------------------------------------------------------------
module lesf_scan
   import lesf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CHAR_W-1:0] cell_char,
   input  logic              last,
   input  logic [CFG_W-1:0]  row_length,
   input  logic [CHAR_W-1:0] obstacle_char,
   input  lb_wr_type         wr,
   output logic [COL_W-1:0]  rd_addr,
   output item_type          item
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             ovf_ff, ovf_in;
   logic [LEN_W-1:0] len;
   logic             row_end;
   logic             last_row;

   always_comb begin
      if (row_length == '0) begin
         len = LEN_W'(1);
      end else if (int'(row_length) > MAX_COLS) begin
         len = LEN_W'(MAX_COLS);
      end else begin
         len = LEN_W'(row_length);
      end
   end

   assign row_end  = ({1'b0, col_ff} + LEN_W'(1)) >= len;
   assign last_row = int'(row_ff) >= (MAX_ROWS - 1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
            ovf_in = 1'b0;
         end else if (row_end) begin
            col_in = '0;
            if (last_row) begin
               ovf_in = 1'b1;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rd_addr = col_ff;

   always_comb begin
      item.col      = col_ff;
      item.row      = row_ff;
      item.row_nz   = (row_ff != '0);
      item.skip     = ovf_ff;
      item.blocked  = (cell_char == obstacle_char);
      item.last     = last;
      item.ovf      = ovf_ff | (row_end & last_row);
      // write to the same column lands in this cycle; the read misses it
      item.fwd      = wr.en && (wr.addr == col_ff);
      item.fwd_size = wr.data;
   end

endmodule

[hdl/lesf_dp_stage.sv]
// ----------------------------------------------------------------------------
// lesf_dp_stage
// Size of the square ending at each cell, best tracking and result register.
// ----------------------------------------------------------------------------
module lesf_dp_stage
   import lesf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  item_type          item_in,
   input  logic [SIZE_W-1:0] rd_data,
   output lb_wr_type         wr,
   output logic              ready,
   input  logic              rsp_tready,
   output logic              rsp_valid,
   output logic [SIZE_W-1:0] square_size,
   output logic [ROW_W-1:0]  top_row,
   output logic [COL_W-1:0]  left_col,
   output logic              rows_exceeded
);

   logic              s1_valid_ff, s1_valid_in;
   item_type          item_ff;
   logic [SIZE_W-1:0] left_ff, left_in;
   logic [SIZE_W-1:0] diag_ff, diag_in;
   logic [SIZE_W-1:0] best_size_ff, best_size_in;
   logic [ROW_W-1:0]  best_row_ff, best_row_in;
   logic [COL_W-1:0]  best_col_ff, best_col_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic              rsp_ovf_ff;

   logic [SIZE_W-1:0] up, left, diag, m, size;
   logic              fire, upd;
   logic [SIZE_W-1:0] nb_size;
   logic [ROW_W-1:0]  nb_row;
   logic [COL_W-1:0]  nb_col;
   logic [ROW_W:0]    row_p1, size_r;
   logic [COL_W+1:0]  col_p1, size_c;
   logic [ROW_W-1:0]  top;
   logic [COL_W-1:0]  lft;

   always_comb begin
      up   = item_ff.row_nz ? (item_ff.fwd ? item_ff.fwd_size : rd_data) : '0;
      left = (item_ff.col != '0) ? left_ff : '0;
      diag = ((item_ff.col != '0) && item_ff.row_nz) ? diag_ff : '0;
      m    = min3_size(left, up, diag);
      if (item_ff.blocked) begin
         size = '0;
      end else if (m == SIZE_SAT) begin
         size = SIZE_SAT;
      end else begin
         size = m + SIZE_W'(1);
      end
   end

   assign fire  = s1_valid_ff && (!item_ff.last || !rsp_valid_ff || rsp_tready);
   assign ready = !s1_valid_ff || fire;

   assign upd     = !item_ff.skip && (size > best_size_ff);
   assign nb_size = upd ? size : best_size_ff;
   assign nb_row  = upd ? item_ff.row : best_row_ff;
   assign nb_col  = upd ? item_ff.col : best_col_ff;

   // top-left corner, clamped at zero
   always_comb begin
      row_p1 = {1'b0, nb_row} + (ROW_W+1)'(1);
      size_r = (ROW_W+1)'(nb_size);
      col_p1 = {2'b00, nb_col} + (COL_W+2)'(1);
      size_c = (COL_W+2)'(nb_size);
      top    = '0;
      lft    = '0;
      if (nb_size != '0) begin
         if (row_p1 >= size_r) begin
            top = ROW_W'(row_p1 - size_r);
         end
         if (col_p1 >= size_c) begin
            lft = COL_W'(col_p1 - size_c);
         end
      end
   end

   always_comb begin
      wr.en   = fire && !item_ff.skip;
      wr.addr = item_ff.col;
      wr.data = size;
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      if (fire && !item_ff.skip) begin
         left_in = size;
         diag_in = up;
      end
      if (fire) begin
         if (item_ff.last) begin
            best_size_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end else begin
            best_size_in = nb_size;
            best_row_in  = nb_row;
            best_col_in  = nb_col;
         end
      end
      if (fire && item_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         left_ff      <= '0;
         diag_ff      <= '0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         left_ff      <= left_in;
         diag_ff      <= diag_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (fire && item_ff.last) begin
         rsp_size_ff <= nb_size;
         rsp_row_ff  <= top;
         rsp_col_ff  <= lft;
         rsp_ovf_ff  <= item_ff.ovf;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign square_size   = rsp_size_ff;
   assign top_row       = rsp_row_ff;
   assign left_col      = rsp_col_ff;
   assign rows_exceeded = rsp_ovf_ff;

`include "assert_macros.svh"

   `ASSERT_CLK(a_best_grows, clock, reset, (fire && !item_ff.last) |=> best_size_ff >= $past(best_size_ff), "best size shrank inside a map")
   `ASSERT_CLK(a_best_clear, clock, reset, (fire && item_ff.last) |=> best_size_ff == '0, "best size not cleared after end of map")
   `ASSERT_CLK(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> $past(fire && item_ff.last), "result without an end-of-map word")
   `ASSERT_NEVER(a_skip_write, clock, reset, wr.en && item_ff.skip, "line buffer written past the row limit")

endmodule
